// ===== rtl/core/sedm_pkg.sv =====
package sedm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int LW_W = 11;
    localparam logic [LW_W-1:0] LW_RESET = 11'd352;

    localparam int ERR_W = 24;
    localparam logic signed [ERR_W-1:0] MAX_GREY  = 24'sd65280;
    localparam logic signed [ERR_W-1:0] THRESHOLD = MAX_GREY / 2;

    localparam logic [7:0] FIRST_BIT = 8'h80;
    localparam logic [7:0] LAST_BIT  = 8'h01;

    typedef struct packed {
        logic [7:0] luma;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] mono_byte;
        logic [6:0] byte_column;
        logic       reverse_row;
        logic       row_done;
    } mono_t;

endpackage

// ===== rtl/core/serpentine_error_diffusion_mono_core.sv =====
// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_ready  pixel_t: luma, frame_start
// mono      out        mono_valid / mono_ready    mono_t: mono_byte, byte_column,
//                                                 reverse_row, row_done
// cfg       in         cfg_wen (no wait)          cfg_wdata: line_width
//
// One pixel per cycle while pixel_ready is high. Each pixel issues its error-line read
// in the stage that accepts it and passes the diffusion adder chain in the stage after;
// a completed byte is registered into the output queue, which drives mono.
// After reset the error line banks are cleared, one row per cycle, over all
// 2*((MAX_WIDTH+3)/2) rows of each bank (1026 by default); pixel_ready stays low meanwhile.
// The output queue holds two bytes; outside the clear, pixel_ready drops only when a third could arrive.
module serpentine_error_diffusion_mono_core
    import sedm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pixel_valid,
    output logic            pixel_ready,
    input  pixel_t          pixel,
    output logic            mono_valid,
    input  logic            mono_ready,
    output mono_t           mono,
    input  logic            cfg_wen,
    input  logic [LW_W-1:0] cfg_wdata
);

    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int EW         = $clog2(LINE_DEPTH);
    localparam int HALF       = (LINE_DEPTH + 1) / 2;
    localparam int BANK_DEPTH = 2 * HALF;
    localparam int BAW        = $clog2(BANK_DEPTH);
    localparam int TOP        = (MAX_WIDTH / 8) * 8;
    localparam int CW         = (EW > LW_W) ? EW : LW_W;

    function automatic logic [BAW-1:0] bank_addr(input logic line, input logic [EW-1:0] e);
        logic [BAW-1:0] half_row;
        half_row = BAW'(e[EW-1:1]);
        return line ? (BAW'(HALF) + half_row) : half_row;
    endfunction

    logic [LW_W-1:0] line_width_reg;
    logic            clearing_reg;
    logic [BAW-1:0]  clr_addr_reg;

    logic [EW-1:0]   column_count_reg;
    logic [EW-1:0]   carry_entry_reg;
    logic            row_parity_reg;

    logic [CW-1:0]   lw_ext;
    logic [EW-1:0]   w_eff;
    logic [EW-1:0]   cnt0;
    logic [EW-1:0]   cnt;
    logic [EW-1:0]   pos;
    logic [EW-1:0]   rd_entry;
    logic [EW-1:0]   wr1;
    logic [EW-1:0]   wr2;
    logic [EW-1:0]   carry_entry_next;
    logic [EW-1:0]   column_count_next;
    logic            rev;
    logic            last;
    logic            first;
    logic            byte_done;
    logic [7:0]      mask;
    logic [EW+6:0]   pos_wide;
    logic            accept;
    logic [BAW-1:0]  rd_addr;

    logic            s2_v_reg;
    logic            s2_byte_reg;
    logic [7:0]      s2_luma_reg;
    logic            s2_rev_reg;
    logic            s2_first_reg;
    logic            s2_last_reg;
    logic [7:0]      s2_mask_reg;
    logic [6:0]      s2_col_reg;
    logic [EW-1:0]   s2_wr1_reg;
    logic [EW-1:0]   s2_wr2_reg;
    logic            s2_rbank_reg;
    logic            s2_fwd_reg;
    logic [ERR_W-1:0] fwd_data_reg;

    logic signed [ERR_W-1:0] c7_reg;
    logic signed [ERR_W-1:0] pnear_reg;
    logic signed [ERR_W-1:0] pfar_reg;
    logic [7:0]              packing_reg;

    logic signed [ERR_W-1:0] rd_val;
    logic signed [ERR_W-1:0] carried;
    logic signed [ERR_W-1:0] acc0;
    logic signed [ERR_W-1:0] acc;
    logic signed [ERR_W-1:0] x3;
    logic signed [ERR_W-1:0] x5;
    logic signed [ERR_W-1:0] x7;
    logic signed [ERR_W-1:0] pn_eff;
    logic signed [ERR_W-1:0] pf_eff;
    logic signed [ERR_W-1:0] wdata;
    logic signed [ERR_W-1:0] wdata2;
    logic                    white;
    logic [7:0]              pk_new;
    logic                    fwd_hit1;
    logic                    fwd_hit2;
    logic [ERR_W-1:0]        fwd_data_next;

    logic             bank_we [2];
    logic [BAW-1:0]   bank_wa [2];
    logic [ERR_W-1:0] bank_wd [2];
    logic [ERR_W-1:0] bank0_q;
    logic [ERR_W-1:0] bank1_q;
    logic [ERR_W-1:0] bank0_mem [BANK_DEPTH];
    logic [ERR_W-1:0] bank1_mem [BANK_DEPTH];

    mono_t       q_mem [2];
    logic        q_wp_reg;
    logic        q_rp_reg;
    logic [1:0]  q_occ_reg;
    logic        push;
    logic        pop;

    // effective width and pixel position
    always_comb
    begin
        lw_ext = CW'({line_width_reg[LW_W-1:3], 3'b000});
        if (lw_ext < CW'(8))
        begin
            w_eff = EW'(8);
        end
        else if (lw_ext > CW'(TOP))
        begin
            w_eff = EW'(TOP);
        end
        else
        begin
            w_eff = EW'(lw_ext);
        end

        cnt0 = pixel.frame_start ? '0 : column_count_reg;
        cnt  = (cnt0 >= w_eff) ? (w_eff - EW'(1)) : cnt0;
        rev  = pixel.frame_start ? 1'b0 : row_parity_reg;
        pos  = rev ? (w_eff - EW'(1) - cnt) : cnt;
        last = (cnt == w_eff - EW'(1));
        first = (cnt == '0);
        byte_done = &cnt[2:0];
        mask = rev ? (LAST_BIT << cnt[2:0]) : (FIRST_BIT >> cnt[2:0]);
        pos_wide = {7'd0, pos};

        rd_entry = first ? (rev ? w_eff : EW'(1)) : carry_entry_reg;
        carry_entry_next = rev ? pos : (pos + EW'(2));
        column_count_next = last ? '0 : (cnt + EW'(1));
        wr1 = rev ? (pos + EW'(2)) : pos;
        wr2 = rev ? EW'(1) : w_eff;
        rd_addr = bank_addr(rev, rd_entry);
    end

    assign pixel_ready = !clearing_reg && ((q_occ_reg == 2'd0) ||
                                           ((q_occ_reg == 2'd1) && !s2_byte_reg));
    assign accept = pixel_valid && pixel_ready;

    // diffusion chain
    always_comb
    begin
        rd_val  = $signed(s2_fwd_reg ? fwd_data_reg : (s2_rbank_reg ? bank1_q : bank0_q));
        carried = s2_first_reg ? rd_val : (rd_val + c7_reg);
        acc0    = (carried >>> 4) +
                  $signed({{(ERR_W-16){1'b0}}, s2_luma_reg, 8'h00});
        white   = (acc0 > THRESHOLD);
        acc     = white ? (acc0 - MAX_GREY) : acc0;
        x3      = (acc <<< 1) + acc;
        x5      = (acc <<< 2) + acc;
        x7      = (acc <<< 3) - acc;
        pn_eff  = s2_first_reg ? '0 : pnear_reg;
        pf_eff  = s2_first_reg ? '0 : pfar_reg;
        wdata   = pn_eff + x3;
        wdata2  = pf_eff + x5;
        pk_new  = (s2_first_reg ? 8'h00 : packing_reg) | (white ? s2_mask_reg : 8'h00);

        fwd_hit1 = s2_v_reg && (!s2_rev_reg == rev) && (s2_wr1_reg == rd_entry);
        fwd_hit2 = s2_v_reg && s2_last_reg && (!s2_rev_reg == rev) &&
                   (s2_wr2_reg == rd_entry);
        fwd_data_next = fwd_hit1 ? wdata : wdata2;
    end

    // bank write ports: clear sweep, or the error below and the row-end edge term
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            bank_we[b] = 1'b0;
            bank_wa[b] = clr_addr_reg;
            bank_wd[b] = '0;
            if (clearing_reg)
            begin
                bank_we[b] = 1'b1;
            end
            else if (s2_v_reg)
            begin
                if (s2_wr1_reg[0] == 1'(b))
                begin
                    bank_we[b] = 1'b1;
                    bank_wa[b] = bank_addr(!s2_rev_reg, s2_wr1_reg);
                    bank_wd[b] = wdata;
                end
                else if (s2_last_reg && (s2_wr2_reg[0] == 1'(b)))
                begin
                    bank_we[b] = 1'b1;
                    bank_wa[b] = bank_addr(!s2_rev_reg, s2_wr2_reg);
                    bank_wd[b] = wdata2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_we[0])
        begin
            bank0_mem[bank_wa[0]] <= bank_wd[0];
        end
        bank0_q <= bank0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bank_we[1])
        begin
            bank1_mem[bank_wa[1]] <= bank_wd[1];
        end
        bank1_q <= bank1_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LW_RESET;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            column_count_reg <= '0;
            row_parity_reg   <= 1'b0;
            carry_entry_reg  <= '0;
            s2_v_reg         <= 1'b0;
            s2_byte_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                line_width_reg <= cfg_wdata;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BAW'(1);
                if (clr_addr_reg == BAW'(BANK_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s2_v_reg <= accept;
            if (accept)
            begin
                column_count_reg <= column_count_next;
                row_parity_reg   <= last ? !rev : rev;
                carry_entry_reg  <= carry_entry_next;
                s2_byte_reg      <= byte_done;
            end
            else
            begin
                s2_byte_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_luma_reg  <= pixel.luma;
            s2_rev_reg   <= rev;
            s2_first_reg <= first;
            s2_last_reg  <= last;
            s2_mask_reg  <= mask;
            s2_col_reg   <= pos_wide[9:3];
            s2_wr1_reg   <= wr1;
            s2_wr2_reg   <= wr2;
            s2_rbank_reg <= rd_entry[0];
            s2_fwd_reg   <= fwd_hit1 || fwd_hit2;
            fwd_data_reg <= fwd_data_next;
        end
        if (s2_v_reg)
        begin
            c7_reg      <= x7;
            pnear_reg   <= wdata2;
            pfar_reg    <= acc;
            packing_reg <= s2_byte_reg ? 8'h00 : pk_new;
        end
    end

    assign push = s2_v_reg && s2_byte_reg;
    assign pop  = mono_valid && mono_ready;
    assign mono_valid = (q_occ_reg != 2'd0);
    assign mono = q_mem[q_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_occ_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_wp_reg <= !q_wp_reg;
            end
            if (pop)
            begin
                q_rp_reg <= !q_rp_reg;
            end
            q_occ_reg <= q_occ_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[q_wp_reg] <= '{mono_byte:   pk_new,
                                 byte_column: s2_col_reg,
                                 reverse_row: s2_rev_reg,
                                 row_done:    s2_last_reg};
        end
    end

endmodule

// ===== rtl/core/sedm_checker.sv =====
module sedm_checker
    import sedm_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_valid,
    input logic   pixel_ready,
    input logic   mono_valid,
    input logic   mono_ready,
    input mono_t  mono
);

    a_mono_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mono_valid && !mono_ready |=> mono_valid && $stable(mono))
        else $error("mono item changed while stalled");

    a_rev_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        mono_valid && mono.reverse_row && mono.row_done |-> mono.byte_column == 7'd0)
        else $error("right-to-left row did not end at the leftmost byte");

    a_byte_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mono_valid) |-> $past(pixel_valid && pixel_ready, 2))
        else $error("byte appeared without a pixel two cycles earlier");

    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !pixel_ready)
        else $error("pixel taken during the line clear after reset");

endmodule

bind serpentine_error_diffusion_mono_core sedm_checker u_sedm_checker (.*);
